@@ hdl/minkowski_segment_generator_macros.svh @@
// Assertion macros for the Minkowski segment generator.
// Used by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef MINKOWSKI_SEGMENT_GENERATOR_MACROS_SVH
`define MINKOWSKI_SEGMENT_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MSEG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MSEG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mseg_pkg.sv @@
// Shared types, constants and the motif table of the Minkowski segment generator.
// No dependencies; used by mseg_addsat, minkowski_segment_generator and its testbench.
package mseg_pkg;

  localparam int unsigned IO_COORD_BITS = 16;
  localparam int unsigned DEPTH_BITS    = 2;
  localparam int unsigned S_TDATA_BITS  = 72;
  localparam int unsigned M_TDATA_BITS  = 64;

  localparam int unsigned MOTIF_SEGS    = 8;
  localparam int unsigned IDX_BITS      = $clog2(MOTIF_SEGS);
  localparam logic [IDX_BITS-1:0] IDX_FIRST = '0;
  localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(MOTIF_SEGS - 1);
  localparam int unsigned QUARTER_SHIFT = 2;

  // Control of the shared adder: subtract the second operand, add a carry in.
  typedef struct packed {
    logic sub;
    logic cin;
  } add_ctl_t;

  // How the end point of a motif piece follows from its start point.
  typedef enum logic [2:0] {
    STEP_ALONG,
    STEP_PERP_NEG,
    STEP_PERP_POS,
    STEP_PERP_BASE,
    STEP_END
  } motif_step_e;

  function automatic motif_step_e motif_step(input logic [IDX_BITS-1:0] idx);
    motif_step_e s;
    case (idx) inside
      3'd0, 3'd2, 3'd5: s = STEP_ALONG;
      3'd1:             s = STEP_PERP_NEG;
      3'd4:             s = STEP_PERP_POS;
      3'd3, 3'd6:       s = STEP_PERP_BASE;
      default:          s = STEP_END;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/mseg_addsat.sv @@
// Shared add/subtract unit with saturation to the signed coordinate range.
// Depends on mseg_pkg for its control struct.
module mseg_addsat #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned SUM_BITS   = 18
) (
  input  logic signed [SUM_BITS-1:0]   op_a_i,
  input  logic signed [SUM_BITS-1:0]   op_b_i,
  input  mseg_pkg::add_ctl_t           ctl_i,
  output logic signed [SUM_BITS-1:0]   sum_o,
  output logic signed [COORD_BITS-1:0] sat_o
);

  logic [SUM_BITS-1:0]          b_eff;
  logic [SUM_BITS-1:0]          sum;
  logic [SUM_BITS-COORD_BITS:0] top_bits;

  always_comb begin
    b_eff    = ctl_i.sub ? ~op_b_i : op_b_i;
    sum      = op_a_i + b_eff + SUM_BITS'(ctl_i.sub | ctl_i.cin);
    top_bits = sum[SUM_BITS-1:COORD_BITS-1];
    sum_o    = sum;
    // The sum fits when all bits above the coordinate sign agree with it.
    if (&top_bits || ~|top_bits) begin
      sat_o = sum[COORD_BITS-1:0];
    end else if (sum[SUM_BITS-1]) begin
      sat_o = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      sat_o = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

endmodule

@@ hdl/minkowski_segment_generator.sv @@
// Top level of the Minkowski segment generator: sequencer, level store, output stage.
// Depends on mseg_pkg, mseg_addsat and minkowski_segment_generator_macros.svh.
//
// One input beat carries a segment and a depth (0 to MAX_DEPTH, larger values
// are clamped); the block returns 8^depth output beats, the pieces of the
// Minkowski curve over the segment in depth-first order, with tlast on the
// final one. The difference, the quarter step and every computed end point
// come from one saturating adder that is shared by these steps: each level
// passes S_DIFF for its difference and S_QUART for its quarter step, each
// piece passes S_STEP for its end point and S_EMIT to load the output
// register, where it waits while the output is stalled, and a return to an
// upper level passes S_POP. The input is ready only while no item is being
// expanded; the last output beat may still wait in the output register when
// the next item is taken.
`include "minkowski_segment_generator_macros.svh"

module minkowski_segment_generator #(
  parameter int unsigned MAX_DEPTH  = 2,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x [15:0], start_y [31:16], end_x [47:32], end_y [63:48],
  // depth [65:64], zero fill [71:66]
  input  logic [mseg_pkg::S_TDATA_BITS-1:0]      s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // seg_start_x [15:0], seg_start_y [31:16], seg_end_x [47:32], seg_end_y [63:48]
  output logic [mseg_pkg::M_TDATA_BITS-1:0]      m_axis_tdata,
  output logic                                   m_axis_tlast
);

  localparam int unsigned IOW  = mseg_pkg::IO_COORD_BITS;
  localparam int unsigned AW   = (COORD_BITS + 2 > IOW) ? COORD_BITS + 2 : IOW;
  localparam int unsigned LW   = (MAX_DEPTH > 0) ? $clog2(MAX_DEPTH + 1) : 1;
  localparam int unsigned NLVL = 2 ** LW;
  localparam int unsigned IB   = mseg_pkg::IDX_BITS;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [AW-1:0]         wide_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_QUART,
    S_STEP,
    S_EMIT,
    S_POP
  } state_e;

  function automatic coord_t sat_in(input logic signed [IOW-1:0] v);
    wide_t                  e;
    logic [AW-COORD_BITS:0] hi;
    coord_t                 r;
    e  = AW'(v);
    hi = e[AW-1:COORD_BITS-1];
    if (&hi || ~|hi) begin
      r = e[COORD_BITS-1:0];
    end else if (e[AW-1]) begin
      r = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic logic [IOW-1:0] to_io(input coord_t c);
    wide_t e;
    e = AW'(c);
    return e[IOW-1:0];
  endfunction

  function automatic wide_t ext(input coord_t c);
    return AW'(c);
  endfunction

  // Sequencer state and output register.
  state_e              state_q;
  logic [LW-1:0]       lvl_q;
  logic [LW-1:0]       depth_q;
  logic [IB-1:0]       idx_q [NLVL];
  logic                out_valid_q;
  logic [IOW-1:0]      out_sx_q, out_sy_q, out_ex_q, out_ey_q;
  logic                out_last_q;

  // Level store: the segment at each level, its orientation and quarter step.
  coord_t              ax_q [NLVL];
  coord_t              ay_q [NLVL];
  coord_t              bx_q [NLVL];
  coord_t              by_q [NLVL];
  logic                horiz_q [NLVL];
  coord_t              d_q [NLVL];
  wide_t               diff_q;

  logic                in_acc;
  logic                out_free;
  logic [mseg_pkg::DEPTH_BITS-1:0] depth_in;
  logic [LW-1:0]       depth_clamp;
  logic [LW-1:0]       chl;
  coord_t              par_ax, par_ay, par_bx, par_by;
  coord_t              chl_ax, chl_ay, chl_bx, chl_by;
  coord_t              em_ax, em_ay, em_bx, em_by;
  logic [IB-1:0]       idx_cur;
  logic                horiz_cur;
  logic                horiz_w;
  coord_t              d_cur;
  coord_t              start_x, start_y;
  coord_t              along_start, perp_start, perp_base;
  coord_t              next_along, next_perp;
  coord_t              next_x, next_y;
  mseg_pkg::motif_step_e step;
  wide_t               op_a, op_b;
  mseg_pkg::add_ctl_t  add_ctl;
  wide_t               add_sum;
  coord_t              add_sat;
  logic                last_w;

  mseg_addsat #(
    .COORD_BITS (COORD_BITS),
    .SUM_BITS   (AW)
  ) u_addsat (
    .op_a_i (op_a),
    .op_b_i (op_b),
    .ctl_i  (add_ctl),
    .sum_o  (add_sum),
    .sat_o  (add_sat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign depth_in      = s_axis_tdata[4*IOW +: mseg_pkg::DEPTH_BITS];
  assign depth_clamp   = (32'(depth_in) > MAX_DEPTH) ? LW'(MAX_DEPTH) : LW'(depth_in);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_ey_q, out_ex_q, out_sy_q, out_sx_q};
  assign m_axis_tlast  = out_last_q;

  always_comb begin
    chl       = lvl_q + LW'(1);
    par_ax    = ax_q[lvl_q];
    par_ay    = ay_q[lvl_q];
    par_bx    = bx_q[lvl_q];
    par_by    = by_q[lvl_q];
    chl_ax    = ax_q[chl];
    chl_ay    = ay_q[chl];
    chl_bx    = bx_q[chl];
    chl_by    = by_q[chl];
    idx_cur   = idx_q[lvl_q];
    horiz_cur = horiz_q[lvl_q];
    d_cur     = d_q[lvl_q];
    horiz_w   = (par_ay == par_by);

    // The first piece starts at the parent start, later ones where the last ended.
    start_x     = (idx_cur == mseg_pkg::IDX_FIRST) ? par_ax : chl_bx;
    start_y     = (idx_cur == mseg_pkg::IDX_FIRST) ? par_ay : chl_by;
    along_start = horiz_cur ? start_x : start_y;
    perp_start  = horiz_cur ? start_y : start_x;
    perp_base   = horiz_cur ? par_ay : par_ax;
    step        = mseg_pkg::motif_step(idx_cur);

    op_a    = '0;
    op_b    = '0;
    add_ctl = '0;
    unique case (state_q)
      S_DIFF: begin
        op_a        = horiz_w ? ext(par_bx) : ext(par_by);
        op_b        = horiz_w ? ext(par_ax) : ext(par_ay);
        add_ctl.sub = 1'b1;
      end
      S_QUART: begin
        // Arithmetic shift rounds down; add one back for a negative remainder.
        op_a        = diff_q >>> mseg_pkg::QUARTER_SHIFT;
        add_ctl.cin = diff_q[AW-1] & (|diff_q[mseg_pkg::QUARTER_SHIFT-1:0]);
      end
      S_STEP: begin
        case (step)
          mseg_pkg::STEP_ALONG: begin
            op_a = ext(along_start);
            op_b = ext(d_cur);
          end
          mseg_pkg::STEP_PERP_NEG: begin
            op_a        = ext(perp_base);
            op_b        = ext(d_cur);
            add_ctl.sub = 1'b1;
          end
          mseg_pkg::STEP_PERP_POS: begin
            op_a = ext(perp_base);
            op_b = ext(d_cur);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    case (step)
      mseg_pkg::STEP_ALONG: begin
        next_along = add_sat;
        next_perp  = perp_start;
      end
      mseg_pkg::STEP_PERP_NEG, mseg_pkg::STEP_PERP_POS: begin
        next_along = along_start;
        next_perp  = add_sat;
      end
      default: begin
        next_along = along_start;
        next_perp  = perp_base;
      end
    endcase
    if (step == mseg_pkg::STEP_END) begin
      next_x = par_bx;
      next_y = par_by;
    end else begin
      next_x = horiz_cur ? next_along : next_perp;
      next_y = horiz_cur ? next_perp : next_along;
    end

    // The leaf is the input segment itself at depth zero, else the child slot.
    if (depth_q == '0) begin
      em_ax = par_ax;
      em_ay = par_ay;
      em_bx = par_bx;
      em_by = par_by;
    end else begin
      em_ax = chl_ax;
      em_ay = chl_ay;
      em_bx = chl_bx;
      em_by = chl_by;
    end

    last_w = 1'b1;
    for (int k = 0; k < NLVL; k++) begin
      if ((LW'(k) < depth_q) && (idx_q[k] != mseg_pkg::IDX_LAST)) begin
        last_w = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ax_q[0] <= sat_in(s_axis_tdata[0*IOW +: IOW]);
      ay_q[0] <= sat_in(s_axis_tdata[1*IOW +: IOW]);
      bx_q[0] <= sat_in(s_axis_tdata[2*IOW +: IOW]);
      by_q[0] <= sat_in(s_axis_tdata[3*IOW +: IOW]);
    end
    if (state_q == S_STEP) begin
      ax_q[chl] <= start_x;
      ay_q[chl] <= start_y;
      bx_q[chl] <= next_x;
      by_q[chl] <= next_y;
    end
    if (state_q == S_DIFF) begin
      horiz_q[lvl_q] <= horiz_w;
      diff_q         <= add_sum;
    end
    if (state_q == S_QUART) begin
      d_q[lvl_q] <= add_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      depth_q     <= '0;
      for (int k = 0; k < NLVL; k++) begin
        idx_q[k] <= '0;
      end
      out_valid_q <= 1'b0;
      out_sx_q    <= '0;
      out_sy_q    <= '0;
      out_ex_q    <= '0;
      out_ey_q    <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // In S_EMIT a beat that leaves is replaced by the next one in the same cycle.
      if (out_valid_q && m_axis_tready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            lvl_q   <= '0;
            depth_q <= depth_clamp;
            state_q <= (depth_clamp == '0) ? S_EMIT : S_DIFF;
          end
        end
        S_DIFF: begin
          idx_q[lvl_q] <= mseg_pkg::IDX_FIRST;
          state_q      <= S_QUART;
        end
        S_QUART: begin
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (chl == depth_q) begin
            state_q <= S_EMIT;
          end else begin
            lvl_q   <= chl;
            state_q <= S_DIFF;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sx_q    <= to_io(em_ax);
            out_sy_q    <= to_io(em_ay);
            out_ex_q    <= to_io(em_bx);
            out_ey_q    <= to_io(em_by);
            out_last_q  <= last_w;
            if (last_w) begin
              for (int k = 0; k < NLVL; k++) begin
                idx_q[k] <= '0;
              end
              state_q <= S_IDLE;
            end else if (idx_cur != mseg_pkg::IDX_LAST) begin
              idx_q[lvl_q] <= idx_cur + IB'(1);
              state_q      <= S_STEP;
            end else begin
              idx_q[lvl_q] <= '0;
              lvl_q        <= lvl_q - LW'(1);
              state_q      <= S_POP;
            end
          end
        end
        S_POP: begin
          if (idx_cur != mseg_pkg::IDX_LAST) begin
            idx_q[lvl_q] <= idx_cur + IB'(1);
            state_q      <= S_STEP;
          end else begin
            idx_q[lvl_q] <= '0;
            lvl_q        <= lvl_q - LW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `MSEG_ASSERT_IMP(a_lvl_within_depth, state_q != S_IDLE, lvl_q <= depth_q,
                   "level above depth")
  `MSEG_ASSERT_IMP(a_depth_clamped, state_q != S_IDLE, depth_q <= LW'(MAX_DEPTH),
                   "depth not clamped")
  `MSEG_ASSERT_NXT(a_last_ends_item, (state_q == S_EMIT) && out_free && last_w,
                   (state_q == S_IDLE) && m_axis_tvalid && m_axis_tlast,
                   "last beat did not end the item")

endmodule

@@ sim/minkowski_segment_generator_tb.sv @@
// Self-checking testbench for minkowski_segment_generator: it drives segment requests and
// checks every returned piece against a built-in Minkowski subdivision predictor.
// Depends on mseg_pkg and the minkowski_segment_generator RTL.
module minkowski_segment_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEVELS = 2;
  localparam int unsigned N_RANDOM   = 460;
  localparam int unsigned LONG_HOLD  = 600;
  localparam int unsigned DRAIN      = 200;
  localparam longint      COORD_MAX  = 32767;
  localparam longint      COORD_MIN  = -32768;

  // One request: start_x in the lowest bits, depth on top.
  typedef struct packed {
    logic [1:0]  depth;
    logic [15:0] end_y;
    logic [15:0] end_x;
    logic [15:0] start_y;
    logic [15:0] start_x;
  } seg_req_t;

  // One emitted piece as it appears on {tlast, tdata}.
  typedef struct packed {
    logic        last;
    logic [15:0] end_y;
    logic [15:0] end_x;
    logic [15:0] start_y;
    logic [15:0] start_x;
  } piece_t;

  typedef struct {
    longint ax;
    longint ay;
    longint bx;
    longint by;
  } span_t;

  typedef enum logic [1:0] {
    PH_SLOW_SINK,
    PH_SLOW_SOURCE,
    PH_FULL_RATE
  } traffic_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mseg_pkg::S_TDATA_BITS-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mseg_pkg::M_TDATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tlast;

  seg_req_t       req_q[$];
  piece_t         piece_q[$];
  int unsigned    total_reqs = 0;
  int unsigned    taken_cnt = 0;
  int unsigned    piece_cnt = 0;
  int unsigned    err_cnt = 0;
  int unsigned    depth_hits[MAX_LEVELS+1] = '{default: 0};
  logic           s_took = 1'b0;
  int unsigned    stall_left = 0;
  int unsigned    hold_idx = 0;
  int unsigned    hold_at[2] = '{60, 400};
  traffic_phase_e phase;

  minkowski_segment_generator #(
    .MAX_DEPTH (MAX_LEVELS),
    .COORD_BITS(mseg_pkg::IO_COORD_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("minkowski_segment_generator_tb: done, errors");
    $finish;
  end

  function automatic longint clamp16(input longint v);
    if (v > COORD_MAX) return COORD_MAX;
    if (v < COORD_MIN) return COORD_MIN;
    return v;
  endfunction

  // The nine corner points of the motif over one segment. Each point along the
  // segment is the previous one plus the quarter step, saturated at every sum.
  function automatic void motif_points(input span_t s, output longint px[9],
                                       output longint py[9]);
    longint d;
    px[0] = s.ax;
    py[0] = s.ay;
    px[8] = s.bx;
    py[8] = s.by;
    if (s.ay == s.by) begin
      d = (s.bx - s.ax) / 4;
      px[1] = clamp16(px[0] + d);
      px[2] = px[1];
      px[3] = clamp16(px[2] + d);
      px[4] = px[3];
      px[5] = px[3];
      px[6] = clamp16(px[3] + d);
      px[7] = px[6];
      py[1] = py[0];
      py[4] = py[0];
      py[7] = py[0];
      py[2] = clamp16(py[0] - d);
      py[3] = py[2];
      py[5] = clamp16(py[0] + d);
      py[6] = py[5];
    end else begin
      d = (s.by - s.ay) / 4;
      py[1] = clamp16(py[0] + d);
      py[2] = py[1];
      py[3] = clamp16(py[2] + d);
      py[4] = py[3];
      py[5] = py[3];
      py[6] = clamp16(py[3] + d);
      py[7] = py[6];
      px[1] = px[0];
      px[4] = px[0];
      px[7] = px[0];
      px[2] = clamp16(px[0] - d);
      px[3] = px[2];
      px[5] = clamp16(px[0] + d);
      px[6] = px[5];
    end
  endfunction

  // Expands one request level by level; concatenating the children of each
  // level in order gives the depth-first order of the leaves.
  function automatic void expand_request(input seg_req_t req);
    span_t       level_q[$];
    span_t       next_q[$];
    span_t       root;
    span_t       c;
    longint      px[9];
    longint      py[9];
    piece_t      p;
    int unsigned lvls;
    root.ax = longint'($signed(req.start_x));
    root.ay = longint'($signed(req.start_y));
    root.bx = longint'($signed(req.end_x));
    root.by = longint'($signed(req.end_y));
    lvls = (req.depth > MAX_LEVELS) ? MAX_LEVELS : req.depth;
    depth_hits[lvls]++;
    level_q.push_back(root);
    repeat (lvls) begin
      next_q.delete();
      foreach (level_q[k]) begin
        motif_points(level_q[k], px, py);
        for (int i = 0; i < mseg_pkg::MOTIF_SEGS; i++) begin
          c.ax = px[i];
          c.ay = py[i];
          c.bx = px[i+1];
          c.by = py[i+1];
          next_q.push_back(c);
        end
      end
      level_q = next_q;
    end
    foreach (level_q[k]) begin
      p.start_x = 16'(level_q[k].ax);
      p.start_y = 16'(level_q[k].ay);
      p.end_x   = 16'(level_q[k].bx);
      p.end_y   = 16'(level_q[k].by);
      p.last    = (k == level_q.size() - 1);
      piece_q.push_back(p);
    end
  endfunction

  function automatic void add_req(input int sx, input int sy, input int ex, input int ey,
                                  input int unsigned dp);
    seg_req_t r;
    r.start_x = 16'(sx);
    r.start_y = 16'(sy);
    r.end_x   = 16'(ex);
    r.end_y   = 16'(ey);
    r.depth   = 2'(dp);
    req_q.push_back(r);
  endfunction

  // Mostly full-range values, with a share of small ones and of the two extremes.
  function automatic int rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return ($urandom_range(1) != 0) ? 32767 : -32768;
    if (pick < 40) return int'($urandom_range(2000)) - 1000;
    return int'($signed(16'($urandom)));
  endfunction

  function automatic bit field_ok(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch on piece %0d: expected %0d, got %0d",
               $realtime, name, piece_cnt, $signed(want), $signed(got));
      return 1'b0;
    end
    return 1'b1;
  endfunction

  always_comb begin
    if (taken_cnt < total_reqs / 3) phase = PH_SLOW_SINK;
    else if (taken_cnt < 2 * total_reqs / 3) phase = PH_SLOW_SOURCE;
    else phase = PH_FULL_RATE;
  end

  // Request driver: a beat stays on the bus until it has been taken.
  always @(negedge clk_i) begin : req_driver
    logic                              nxt_valid;
    logic [mseg_pkg::S_TDATA_BITS-1:0] nxt_data;
    int unsigned                       idle_pct;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    case (phase)
      PH_SLOW_SINK:   idle_pct = 13;
      PH_SLOW_SOURCE: idle_pct = 87;
      default:        idle_pct = 0;
    endcase
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!s_axis_tvalid || s_took) begin
      if (req_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = mseg_pkg::S_TDATA_BITS'(req_q.pop_front());
      end else begin
        nxt_valid = 1'b0;
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  // Long output hold-offs so the block fills up and stops taking requests.
  always @(negedge clk_i) begin : long_hold
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (hold_idx < 2 && taken_cnt == hold_at[hold_idx]) begin
      stall_left <= LONG_HOLD;
      hold_idx   <= hold_idx + 1;
    end
  end

  always @(negedge clk_i) begin : piece_sink
    int unsigned idle_pct;
    case (phase)
      PH_SLOW_SINK:   idle_pct = 87;
      PH_SLOW_SOURCE: idle_pct = 13;
      default:        idle_pct = 0;
    endcase
    if (!rst_ni || stall_left != 0) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin : beat_monitor
    piece_t got;
    piece_t want;
    bit     ok;
    s_took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expand_request(seg_req_t'(s_axis_tdata[$bits(seg_req_t)-1:0]));
        taken_cnt <= taken_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tlast, m_axis_tdata};
        if (piece_q.size() == 0) begin
          $display("%0t: unexpected piece: expected none, got (%0d,%0d)-(%0d,%0d) last %0b",
                   $realtime, $signed(got.start_x), $signed(got.start_y),
                   $signed(got.end_x), $signed(got.end_y), got.last);
          err_cnt++;
        end else begin
          want = piece_q.pop_front();
          ok = field_ok("seg_start_x", want.start_x, got.start_x);
          ok = field_ok("seg_start_y", want.start_y, got.start_y) && ok;
          ok = field_ok("seg_end_x", want.end_x, got.end_x) && ok;
          ok = field_ok("seg_end_y", want.end_y, got.end_y) && ok;
          ok = field_ok("last", 16'(want.last), 16'(got.last)) && ok;
          if (!ok) err_cnt++;
        end
        piece_cnt++;
      end
    end
  end

  initial begin : stimulus
    int unsigned kind;
    int          sx;
    int          sy;
    int          ex;
    int          ey;

    // Degenerate points, the coordinate extremes, saturation on both sides of
    // both orientations, truncation of odd quarter steps, and depth clamping.
    add_req(0, 0, 0, 0, 0);
    add_req(0, 0, 0, 0, 2);
    add_req(-32768, -32768, 32767, 32767, 0);
    add_req(32767, 32767, -32768, -32768, 1);
    add_req(-32768, 32767, 32767, 32767, 1);
    add_req(-32768, -32768, 32767, -32768, 2);
    add_req(32767, -32768, -32768, -32768, 2);
    add_req(-32768, -32768, -32768, 32767, 1);
    add_req(32767, 32767, 32767, -32768, 2);
    add_req(0, 0, 7, 0, 1);
    add_req(0, 0, -7, 0, 1);
    add_req(5, 100, 5, 97, 1);
    add_req(100, 200, 1000, 200, 3);
    add_req(-1, -1, -1, -1, 3);
    add_req(1000, -2000, -3000, 4000, 2);
    add_req(0, 32767, 0, -32768, 0);
    add_req(-32768, 0, 32767, 0, 3);
    add_req(-20000, 300, 20000, 300, 2);
    add_req(32767, 0, -32768, 0, 2);
    add_req(0, -32768, 0, 32767, 2);

    // Random part: many horizontal segments, since equal y values are rare
    // in uniform data, and a few degenerate ones.
    repeat (N_RANDOM) begin
      kind = $urandom_range(99);
      sx = rand_coord();
      sy = rand_coord();
      ex = rand_coord();
      ey = rand_coord();
      if (kind < 40) begin
        ey = sy;
      end else if (kind < 45) begin
        ex = sx;
        ey = sy;
      end
      add_req(sx, sy, ex, ey, $urandom_range(3));
    end
    total_reqs = req_q.size();

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (piece_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Checked %0d pieces from %0d segment requests (depth 0/1/2: %0d/%0d/%0d),",
             piece_cnt, taken_cnt, depth_hits[0], depth_hits[1], depth_hits[2]);
    $display("with saturation, truncation, clamped depth and %0d long output holds.",
             hold_idx);
    if (err_cnt == 0) begin
      $display("minkowski_segment_generator_tb: done, clean");
    end else begin
      $display("minkowski_segment_generator_tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/mseg_pkg.sv
hdl/mseg_addsat.sv
hdl/minkowski_segment_generator.sv
sim/minkowski_segment_generator_tb.sv
